// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL of the airspeed factor block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// ----- hw/rtl/eas_tas_pkg.sv -----
// Package with constants and codes of the EAS to TAS factor block.
`default_nettype none

package eas_tas_pkg;

   // Width of the result and its saturated value
   localparam int FACTOR_W = 24;
   localparam logic [FACTOR_W-1:0] FACTOR_MAX = 24'hFFFFFF;

   // Quotient is kept below 2^48, so its root fits the 24-bit factor
   localparam int QUOT_W = 48;
   localparam int ROOT_STEPS = QUOT_W / 2;

   // Ratio constant 351.8935 scaled by 10000, over 10000 * 2000
   localparam int NUM_W = 22;
   localparam logic [NUM_W-1:0] RATIO_NUM = 22'd3518935;
   localparam int DEN_CONST_W = 25;
   localparam logic [DEN_CONST_W-1:0] RATIO_DEN = 25'd20000000;
   localparam int PRESSURE_W = 17;

   // Temperature held as 2000 * kelvin: 2000*tg + 546300 - 13*altitude
   localparam int TEMP_SCALE = 2000;
   localparam int TEMP_OFFSET = 546300;
   localparam int LAPSE_RATE = 13;

   localparam logic [15:0] HYSTERESIS_RESET = 16'd100;

   // Result source codes
   localparam logic [1:0] SRC_UNITY = 2'd0;
   localparam logic [1:0] SRC_CACHED = 2'd1;
   localparam logic [1:0] SRC_COMPUTED = 2'd2;
   localparam logic [1:0] SRC_SATURATED = 2'd3;

   // Sequencer states
   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_CHECK  = 7'b0000010,
      ST_MUL    = 7'b0000100,
      ST_INIT   = 7'b0001000,
      ST_DIV    = 7'b0010000,
      ST_SQRT   = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/airspeed_eas_to_tas_factor.sv -----
// EAS to TAS factor: unity, cached or zero-pressure results go from the check state straight
// to the finish state. A computed factor passes through check, multiply, divide setup, 48 divide
// steps, 24 root steps and output load on one shared subtractor; a quotient overflow ends at setup.
// One request at a time: the next is taken in the idle state after the result is loaded, and
// the finish state waits while the output register holds a result that is not being read.
// Synchronous active-high reset clears the sequencer, cache and output valid; band resets to 100.
`default_nettype none

module airspeed_eas_to_tas_factor #(
   parameter int FRACTION_BITS = 16,
   parameter int ALTITUDE_BITS = 21
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // Configuration write
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [15:0]                           csr_altitude_hysteresis,
   // Request channel
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire                                   req_armed,
   input  wire                                   req_baro_present,
   input  wire  signed [ALTITUDE_BITS-1:0]       req_altitude,
   input  wire  signed [7:0]                     req_ground_temperature,
   input  wire  [eas_tas_pkg::PRESSURE_W-1:0]    req_pressure,
   // Result channel
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output logic [eas_tas_pkg::FACTOR_W-1:0]      rsp_tas_factor,
   output logic [1:0]                            rsp_source
);

   localparam int FW = eas_tas_pkg::FACTOR_W;
   localparam int QW = eas_tas_pkg::QUOT_W;
   localparam int PW = eas_tas_pkg::PRESSURE_W;
   // Signed temperature sum and clamped magnitude
   localparam int TS_W = ALTITUDE_BITS + 6;
   localparam int T_W = TS_W - 1;
   localparam int A_W = T_W + eas_tas_pkg::NUM_W;
   localparam int DEN_W = PW + eas_tas_pkg::DEN_CONST_W;
   localparam int REM_W = FW + 2;
   localparam int SHIFT = QW - 2 * FRACTION_BITS;
   localparam int DIFF_W = ALTITUDE_BITS + 1;
   // Shared subtractor width covers every operand it sees
   localparam int SW0 = (A_W > DEN_W + 1) ? A_W : DEN_W + 1;
   localparam int SW = (SW0 > REM_W + 2) ? SW0 : REM_W + 2;
   localparam int CNT_W = 6;
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QW - 1);
   localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(eas_tas_pkg::ROOT_STEPS - 1);
   localparam logic [FW-1:0] UNITY =
      (FRACTION_BITS >= FW) ? eas_tas_pkg::FACTOR_MAX : FW'(1 << FRACTION_BITS);
   localparam logic signed [TS_W-1:0] K_SCALE = TS_W'(eas_tas_pkg::TEMP_SCALE);
   localparam logic signed [TS_W-1:0] K_OFFSET = TS_W'(eas_tas_pkg::TEMP_OFFSET);
   localparam logic signed [TS_W-1:0] K_LAPSE = TS_W'(eas_tas_pkg::LAPSE_RATE);

   eas_tas_pkg::state_type state_ff, state_in;

   logic [15:0]                     hyst_ff, hyst_in;
   logic [FW-1:0]                   cached_factor_ff, cached_factor_in;
   logic signed [ALTITUDE_BITS-1:0] cached_alt_ff, cached_alt_in;

   logic                            armed_ff, armed_in;
   logic                            baro_ff, baro_in;
   logic signed [ALTITUDE_BITS-1:0] alt_ff, alt_in;
   logic signed [7:0]               tg_ff, tg_in;
   logic [PW-1:0]                   p_ff, p_in;

   logic [T_W-1:0]                  t_ff, t_in;
   logic [DEN_W-1:0]                den_ff, den_in;
   logic [A_W-1:0]                  a_ff, a_in;
   logic [DEN_W-1:0]                r_ff, r_in;
   logic [QW-1:0]                   w_ff, w_in;
   logic [REM_W-1:0]                rem_ff, rem_in;
   logic [FW-1:0]                   root_ff, root_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic [FW-1:0]                   factor_ff, factor_in;
   logic [1:0]                      source_ff, source_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]                   rsp_factor_ff, rsp_factor_in;
   logic [1:0]                      rsp_source_ff, rsp_source_in;

   // Shared subtractor
   logic [SW-1:0]                   sub_a, sub_b;
   logic [SW:0]                     sub_diff;
   logic                            sub_ge;

   // Check-stage terms
   logic signed [DIFF_W-1:0]        alt_diff;
   logic [DIFF_W-1:0]               alt_dist;
   logic                            in_band;
   logic signed [TS_W-1:0]          t_sum;
   logic [A_W-1:0]                  a_high;
   logic [A_W+2*FRACTION_BITS-1:0]  a_cat;
   logic                            out_free;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == eas_tas_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_tas_factor = rsp_factor_ff;
   assign rsp_source = rsp_source_ff;

   // Cache band test and temperature sum
   assign alt_diff = DIFF_W'(alt_ff) - DIFF_W'(cached_alt_ff);
   assign alt_dist = alt_diff[DIFF_W-1] ? DIFF_W'(-alt_diff) : DIFF_W'(alt_diff);
   assign in_band = (alt_dist < DIFF_W'(hyst_ff)) && (cached_factor_ff != '0);
   assign t_sum = TS_W'(tg_ff) * K_SCALE + K_OFFSET - TS_W'(alt_ff) * K_LAPSE;

   // Divide setup: high part of the scaled dividend and its low 48 bits
   assign a_high = A_W'(a_ff >> SHIFT);
   assign a_cat = {a_ff, (2 * FRACTION_BITS)'(0)};
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Select subtractor operands by step
   always_comb begin
      sub_a = SW'(a_high);
      sub_b = SW'(den_ff);
      if (state_ff == eas_tas_pkg::ST_DIV) begin
         sub_a = SW'({r_ff, w_ff[QW-1]});
         sub_b = SW'(den_ff);
      end else if (state_ff == eas_tas_pkg::ST_SQRT) begin
         sub_a = SW'({rem_ff, w_ff[QW-1:QW-2]});
         sub_b = SW'({root_ff, 2'b01});
      end
   end

   assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_ge = ~sub_diff[SW];

   // Sequencer
   always_comb begin
      state_in = state_ff;
      hyst_in = hyst_ff;
      cached_factor_in = cached_factor_ff;
      cached_alt_in = cached_alt_ff;
      armed_in = armed_ff;
      baro_in = baro_ff;
      alt_in = alt_ff;
      tg_in = tg_ff;
      p_in = p_ff;
      t_in = t_ff;
      den_in = den_ff;
      a_in = a_ff;
      r_in = r_ff;
      w_in = w_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      cnt_in = cnt_ff;
      factor_in = factor_ff;
      source_in = source_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_factor_in = rsp_factor_ff;
      rsp_source_in = rsp_source_ff;

      if (csr_valid) begin
         hyst_in = csr_altitude_hysteresis;
      end

      unique case (state_ff)
         eas_tas_pkg::ST_IDLE: begin
            // Capture the request
            if (req_valid) begin
               armed_in = req_armed;
               baro_in = req_baro_present;
               alt_in = req_altitude;
               tg_in = req_ground_temperature;
               p_in = req_pressure;
               state_in = eas_tas_pkg::ST_CHECK;
            end
         end
         eas_tas_pkg::ST_CHECK: begin
            // Pick unity, cached or a fresh computation
            t_in = t_sum[TS_W-1] ? '0 : T_W'(t_sum);
            den_in = DEN_W'(p_ff) * DEN_W'(eas_tas_pkg::RATIO_DEN);
            if (!armed_ff || !baro_ff) begin
               factor_in = UNITY;
               source_in = eas_tas_pkg::SRC_UNITY;
               state_in = eas_tas_pkg::ST_FINISH;
            end else if (in_band) begin
               factor_in = cached_factor_ff;
               source_in = eas_tas_pkg::SRC_CACHED;
               state_in = eas_tas_pkg::ST_FINISH;
            end else if (p_ff == '0) begin
               factor_in = eas_tas_pkg::FACTOR_MAX;
               source_in = eas_tas_pkg::SRC_SATURATED;
               state_in = eas_tas_pkg::ST_FINISH;
            end else begin
               state_in = eas_tas_pkg::ST_MUL;
            end
         end
         eas_tas_pkg::ST_MUL: begin
            a_in = A_W'(t_ff) * A_W'(eas_tas_pkg::RATIO_NUM);
            state_in = eas_tas_pkg::ST_INIT;
         end
         eas_tas_pkg::ST_INIT: begin
            // Saturate when the quotient would reach 2^48
            if (sub_ge) begin
               factor_in = eas_tas_pkg::FACTOR_MAX;
               source_in = eas_tas_pkg::SRC_SATURATED;
               state_in = eas_tas_pkg::ST_FINISH;
            end else begin
               r_in = DEN_W'(a_high);
               w_in = a_cat[QW-1:0];
               cnt_in = '0;
               state_in = eas_tas_pkg::ST_DIV;
            end
         end
         eas_tas_pkg::ST_DIV: begin
            // One restoring divide step; quotient bits shift in from the right
            r_in = sub_ge ? DEN_W'(sub_diff) : DEN_W'(sub_a);
            w_in = {w_ff[QW-2:0], sub_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               cnt_in = '0;
               rem_in = '0;
               root_in = '0;
               state_in = eas_tas_pkg::ST_SQRT;
            end
         end
         eas_tas_pkg::ST_SQRT: begin
            // One root digit from two quotient bits
            rem_in = sub_ge ? REM_W'(sub_diff) : REM_W'(sub_a);
            root_in = {root_ff[FW-2:0], sub_ge};
            w_in = {w_ff[QW-3:0], 2'b00};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SQRT_LAST) begin
               factor_in = {root_ff[FW-2:0], sub_ge};
               source_in = eas_tas_pkg::SRC_COMPUTED;
               state_in = eas_tas_pkg::ST_FINISH;
            end
         end
         eas_tas_pkg::ST_FINISH: begin
            // Load the output register and refresh the cache on a computed or saturated result
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_factor_in = factor_ff;
               rsp_source_in = source_ff;
               if (source_ff == eas_tas_pkg::SRC_COMPUTED ||
                   source_ff == eas_tas_pkg::SRC_SATURATED) begin
                  cached_factor_in = factor_ff;
                  cached_alt_in = alt_ff;
               end
               state_in = eas_tas_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = eas_tas_pkg::ST_IDLE;
         end
      endcase
   end

   // Control and cache registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= eas_tas_pkg::ST_IDLE;
         hyst_ff <= eas_tas_pkg::HYSTERESIS_RESET;
         cached_factor_ff <= '0;
         cached_alt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         hyst_ff <= hyst_in;
         cached_factor_ff <= cached_factor_in;
         cached_alt_ff <= cached_alt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and datapath registers
   always_ff @(posedge clock) begin
      armed_ff <= armed_in;
      baro_ff <= baro_in;
      alt_ff <= alt_in;
      tg_ff <= tg_in;
      p_ff <= p_in;
      t_ff <= t_in;
      den_ff <= den_in;
      a_ff <= a_in;
      r_ff <= r_in;
      w_ff <= w_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      cnt_ff <= cnt_in;
      factor_ff <= factor_in;
      source_ff <= source_in;
      rsp_factor_ff <= rsp_factor_in;
      rsp_source_ff <= rsp_source_in;
   end

`include "assert_macros.svh"

   `ASSERT_IMP(a_sat_is_max, clock, reset,
      rsp_valid_ff && (rsp_source_ff == eas_tas_pkg::SRC_SATURATED),
      rsp_factor_ff == eas_tas_pkg::FACTOR_MAX)
   `ASSERT_IMP(a_cached_matches, clock, reset,
      rsp_valid_ff && (rsp_source_ff == eas_tas_pkg::SRC_CACHED),
      (rsp_factor_ff == cached_factor_ff) && (cached_factor_ff != '0))
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_IMP(a_div_count, clock, reset,
      state_ff == eas_tas_pkg::ST_DIV, cnt_ff <= DIV_LAST)

endmodule

`default_nettype wire

// ----- tb/airspeed_factor_checker.sv -----
// Checker for the EAS to TAS factor block: predicts each result and compares it.
module airspeed_factor_checker (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_valid,
   input  wire                                csr_ready,
   input  wire  [15:0]                        csr_altitude_hysteresis,
   input  wire                                req_valid,
   input  wire                                req_ready,
   input  wire                                req_armed,
   input  wire                                req_baro_present,
   input  wire  signed [20:0]                 req_altitude,
   input  wire  signed [7:0]                  req_ground_temperature,
   input  wire  [eas_tas_pkg::PRESSURE_W-1:0] req_pressure,
   input  wire                                rsp_valid,
   input  wire                                rsp_ready,
   input  wire  [eas_tas_pkg::FACTOR_W-1:0]   rsp_tas_factor,
   input  wire  [1:0]                         rsp_source,
   output int                                 failures,
   output int                                 outstanding
);

   localparam int FRAC = 16;
   localparam int FW = eas_tas_pkg::FACTOR_W;
   localparam int PW = eas_tas_pkg::PRESSURE_W;

   typedef struct packed {
      logic [FW-1:0] factor;
      logic [1:0]    source;
   } factor_result_type;

   // Expected factors in request order, plus a private copy of the cache
   factor_result_type   expected_factors[$];
   logic [15:0]         band;
   logic [FW-1:0]       cache_factor;
   longint              cache_altitude;
   int                  result_index;
   factor_result_type   got_factor;
   factor_result_type   want_factor;

   // Work out the factor for one request and update the cache
   function automatic factor_result_type predict_factor(
      input logic                  armed,
      input logic                  baro,
      input logic signed [20:0]    alt,
      input logic signed [7:0]     tg,
      input logic [PW-1:0]         pres
   );
      factor_result_type   res;
      longint              alt_gap;
      longint              kelvin;
      logic [95:0]         numer;
      logic [95:0]         denom;
      logic [95:0]         quot;
      logic [FW-1:0]       root;
      logic [FW-1:0]       trial;
      quot = '0;
      if (!armed || !baro) begin
         res.factor = FW'(1) << FRAC;
         res.source = eas_tas_pkg::SRC_UNITY;
         return res;
      end
      // Reuse a nonzero cache while strictly inside the band
      alt_gap = longint'(alt) - cache_altitude;
      if (alt_gap < 0) begin
         alt_gap = -alt_gap;
      end
      if (alt_gap < longint'(band) && cache_factor != '0) begin
         res.factor = cache_factor;
         res.source = eas_tas_pkg::SRC_CACHED;
         return res;
      end
      // Temperature as 2000 * kelvin, clamped at absolute zero
      kelvin = longint'(eas_tas_pkg::TEMP_SCALE) * longint'(tg)
               + longint'(eas_tas_pkg::TEMP_OFFSET)
               - longint'(eas_tas_pkg::LAPSE_RATE) * longint'(alt);
      if (kelvin < 0) begin
         kelvin = 0;
      end
      res.source = eas_tas_pkg::SRC_COMPUTED;
      if (pres == '0) begin
         res.source = eas_tas_pkg::SRC_SATURATED;
      end else begin
         numer = (96'(kelvin) * 96'(eas_tas_pkg::RATIO_NUM)) << (2 * FRAC);
         denom = 96'(pres) * 96'(eas_tas_pkg::RATIO_DEN);
         quot = numer / denom;
         if (quot >= (96'd1 << eas_tas_pkg::QUOT_W)) begin
            res.source = eas_tas_pkg::SRC_SATURATED;
         end
      end
      if (res.source == eas_tas_pkg::SRC_SATURATED) begin
         res.factor = eas_tas_pkg::FACTOR_MAX;
      end else begin
         // Floor square root, one bit at a time from the top
         root = '0;
         for (int b = FW - 1; b >= 0; b--) begin
            trial = root | (FW'(1) << b);
            if (96'(trial) * 96'(trial) <= quot) begin
               root = trial;
            end
         end
         res.factor = root;
      end
      cache_factor = res.factor;
      cache_altitude = longint'(alt);
      return res;
   endfunction

   // Count a failure, print only the first few
   function automatic void note_failure(input string msg);
      if (failures < 10) begin
         $display("%s", msg);
      end
      failures++;
   endfunction

   // Track configuration, queue predictions, compare results
   always @(posedge clock) begin
      if (reset) begin
         band = eas_tas_pkg::HYSTERESIS_RESET;
         cache_factor = '0;
         cache_altitude = 0;
         expected_factors.delete();
         failures = 0;
         result_index = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            band = csr_altitude_hysteresis;
         end
         if (req_valid && req_ready) begin
            expected_factors.push_back(predict_factor(req_armed, req_baro_present,
               req_altitude, req_ground_temperature, req_pressure));
         end
         if (rsp_valid && rsp_ready) begin
            got_factor.factor = rsp_tas_factor;
            got_factor.source = rsp_source;
            if (expected_factors.size() == 0) begin
               note_failure($sformatf("result %0d: none pending, got factor 0x%06h source %0d",
                  result_index, got_factor.factor, got_factor.source));
            end else begin
               want_factor = expected_factors.pop_front();
               if (got_factor.factor !== want_factor.factor ||
                   got_factor.source !== want_factor.source) begin
                  note_failure($sformatf(
                     "result %0d: expected factor 0x%06h source %0d, got 0x%06h source %0d",
                     result_index, want_factor.factor, want_factor.source,
                     got_factor.factor, got_factor.source));
               end
            end
            result_index++;
         end
      end
      outstanding = expected_factors.size();
   end

endmodule

// ----- tb/tb_airspeed_eas_to_tas_factor.sv -----
// Testbench top for the EAS to TAS factor block: stimulus, flow control and verdict.
module tb_airspeed_eas_to_tas_factor;

   localparam int ALT_W = 21;
   localparam int PW = eas_tas_pkg::PRESSURE_W;
   localparam int FW = eas_tas_pkg::FACTOR_W;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_valid;
   wire                   csr_ready;
   logic [15:0]           csr_altitude_hysteresis;
   logic                  req_valid;
   wire                   req_ready;
   logic                  req_armed;
   logic                  req_baro_present;
   logic signed [ALT_W-1:0] req_altitude;
   logic signed [7:0]     req_ground_temperature;
   logic [PW-1:0]         req_pressure;
   wire                   rsp_valid;
   logic                  rsp_ready;
   wire [FW-1:0]          rsp_tas_factor;
   wire [1:0]             rsp_source;
   int                    failures;
   int                    outstanding;

   // Stimulus controls; hold_off_go is shared with the receiver
   bit                    hold_off_go;
   bit                    calm;
   logic [15:0]           band;
   int                    anchor;

   airspeed_eas_to_tas_factor dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_altitude_hysteresis(csr_altitude_hysteresis),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_armed              (req_armed),
      .req_baro_present       (req_baro_present),
      .req_altitude           (req_altitude),
      .req_ground_temperature (req_ground_temperature),
      .req_pressure           (req_pressure),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_tas_factor         (rsp_tas_factor),
      .rsp_source             (rsp_source)
   );

   airspeed_factor_checker checker_inst (
      .clock                  (clock),
      .reset                  (reset),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_altitude_hysteresis(csr_altitude_hysteresis),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_armed              (req_armed),
      .req_baro_present       (req_baro_present),
      .req_altitude           (req_altitude),
      .req_ground_temperature (req_ground_temperature),
      .req_pressure           (req_pressure),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_tas_factor         (rsp_tas_factor),
      .rsp_source             (rsp_source),
      .failures               (failures),
      .outstanding            (outstanding)
   );

   always #5 clock = ~clock;

   // Bound the run
   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 50);
   endfunction

   // Offer one request, hold it until taken, then idle for a random gap, which may be none
   task automatic send_request(input bit armed, input bit baro, input int alt,
                               input int tg, input int pres);
      int gap;
      req_valid <= 1'b1;
      req_armed <= armed;
      req_baro_present <= baro;
      req_altitude <= ALT_W'(alt);
      req_ground_temperature <= 8'(tg);
      req_pressure <= PW'(pres);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Drain the block, then write the hysteresis band
   task automatic write_band(input logic [15:0] value);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      csr_valid <= 1'b1;
      csr_altitude_hysteresis <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      band = value;
   endtask

   // Random request: mostly armed, altitude often near the last one or on the band edge
   task automatic send_random_request();
      int alt;
      int tg;
      int pres;
      int offset;
      int r;
      bit armed;
      bit baro;
      logic signed [ALT_W-1:0] alt_bits;
      armed = 1'b1;
      baro = 1'b1;
      if ($urandom_range(0, 99) < 10) begin
         armed = 1'($urandom);
         baro = 1'($urandom);
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3: alt = anchor + int'($urandom_range(0, 2 * band + 4)) - (int'(band) + 2);
         4: begin
            offset = int'(band) + int'($urandom_range(0, 2)) - 1;
            alt = $urandom_range(0, 1) ? anchor + offset : anchor - offset;
         end
         5, 6: alt = int'($urandom_range(0, 20500)) - 500;
         7, 8: alt = int'($urandom);
         default: begin
            case ($urandom_range(0, 3))
               0: alt = -1048576;
               1: alt = 1048575;
               2: alt = -1;
               default: alt = 0;
            endcase
         end
      endcase
      alt_bits = ALT_W'(alt);
      if (armed && baro) begin
         anchor = int'(alt_bits);
      end
      if ($urandom_range(0, 99) < 60) begin
         tg = int'($urandom_range(0, 65)) - 20;
      end else begin
         tg = int'($urandom);
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
         pres = 0;
      end else if (r < 10) begin
         pres = $urandom_range(1, 200);
      end else if (r < 30) begin
         pres = int'($urandom);
      end else begin
         pres = $urandom_range(20000, 108000);
      end
      send_request(armed, baro, alt, tg, pres);
   endtask

   // Receiver: random stalls, plus one long hold-off on request
   initial begin
      int gap;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (hold_off_go) begin
            hold_off_go = 1'b0;
            rsp_ready <= 1'b0;
            repeat (400) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   end

   // Sender: directed cases, then random phases over several band settings
   initial begin
      logic [15:0] settings [6];
      int ph;
      int i;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_altitude_hysteresis = '0;
      req_valid = 1'b0;
      req_armed = 1'b0;
      req_baro_present = 1'b0;
      req_altitude = '0;
      req_ground_temperature = '0;
      req_pressure = '0;
      calm = 1'b0;
      hold_off_go = 1'b0;
      band = eas_tas_pkg::HYSTERESIS_RESET;
      anchor = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Unity cases, cache hits and misses around the default band
      write_band(eas_tas_pkg::HYSTERESIS_RESET);
      send_request(1'b0, 1'b1, 0, 15, 101325);
      send_request(1'b1, 1'b0, 0, 15, 101325);
      send_request(1'b0, 1'b0, 1048575, 127, 131071);
      send_request(1'b1, 1'b1, 0, 15, 101325);
      send_request(1'b1, 1'b1, 50, 15, 101325);
      send_request(1'b1, 1'b1, 100, 20, 90000);
      send_request(1'b1, 1'b1, 199, 15, 101325);
      // Zero pressure saturates, then a reuse of the saturated cache
      send_request(1'b1, 1'b1, 5000, 15, 0);
      send_request(1'b1, 1'b1, 5050, 15, 101325);
      // Factor too large for the output
      send_request(1'b1, 1'b1, 20000, 127, 1);
      // Below absolute zero: zero factor, and a zero cache is not reused
      send_request(1'b1, 1'b1, 1048575, -64, 50000);
      send_request(1'b1, 1'b1, 1048575, -64, 50000);
      send_request(1'b1, 1'b1, -1048576, 127, 131071);
      send_request(1'b1, 1'b1, -1048576, -128, 1);
      send_request(1'b1, 1'b1, 0, -128, 131071);
      send_request(1'b1, 1'b1, 42000, 0, 131071);
      send_request(1'b1, 1'b1, 42024, 0, 131071);
      // Zero band never reuses
      write_band(16'd0);
      send_request(1'b1, 1'b1, 0, 15, 101325);
      send_request(1'b1, 1'b1, 0, 15, 101325);
      // Widest band, reuse at its inner edge and near the cached altitude
      write_band(16'hFFFF);
      send_request(1'b1, 1'b1, 65534, 15, 101325);
      send_request(1'b1, 1'b1, -1, 15, 101325);
      send_request(1'b1, 1'b1, 65533, 15, 101325);

      settings[0] = 16'd0;
      settings[1] = 16'hFFFF;
      settings[2] = 16'd1;
      settings[3] = 16'd500;
      settings[4] = 16'($urandom);
      settings[5] = eas_tas_pkg::HYSTERESIS_RESET;
      for (ph = 0; ph < 6; ph++) begin
         write_band(settings[ph]);
         // In one phase, stall the receiver while requests keep coming
         if (ph == 2) begin
            hold_off_go = 1'b1;
         end
         for (i = 0; i < 300; i++) begin
            calm = ((i % 100) < 15) || (ph == 2 && i < 40);
            send_random_request();
         end
         calm = 1'b0;
      end

      // Drain and give the verdict
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- airspeed_eas_to_tas_factor.f -----
+incdir+hw/rtl
hw/rtl/eas_tas_pkg.sv
hw/rtl/airspeed_eas_to_tas_factor.sv
tb/airspeed_factor_checker.sv
tb/tb_airspeed_eas_to_tas_factor.sv
